@@ src/bfa_pkg.sv @@
// Package of the best-fit block allocator: shared types, codes and constants.
// Used by all allocator modules; depends on nothing.
package bfa_pkg;

  localparam int unsigned MAX_BLOCKS_DEF   = 64;
  localparam int unsigned HEADER_BYTES_DEF = 12;

  localparam int unsigned DATA_W     = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [31:0] HEAP_BASE_RST  = 32'h0000_0000;
  localparam logic [31:0] HEAP_LIMIT_RST = 32'hFFFF_FFFF;

  // Register index, taken from paddr[2].
  localparam logic REG_HEAP_BASE  = 1'b0;
  localparam logic REG_HEAP_LIMIT = 1'b1;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_UNKNOWN = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  // One row of the block table.
  typedef struct packed {
    logic        free;
    logic [31:0] size;
    logic [31:0] start;
  } entry_t;

  // Configuration seen by the controller.
  typedef struct packed {
    logic [31:0] limit;
    logic        reload;
    logic [31:0] reload_value;
  } cfg_t;

endpackage

@@ src/bfa_req_if.sv @@
// Request channel of the allocator: valid/ready plus command payload.
// Stand-alone; no package needed.
interface bfa_req_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] req_size;
  logic [31:0] release_address;

  modport source (output valid, cmd, req_size, release_address, input ready);
  modport sink   (input valid, cmd, req_size, release_address, output ready);
endinterface

@@ src/bfa_rsp_if.sv @@
// Response channel of the allocator: valid/ready plus result payload.
// Stand-alone; no package needed.
interface bfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_address;
  logic [1:0]  status;

  modport source (output valid, data_address, status, input ready);
  modport sink   (input valid, data_address, status, output ready);
endinterface

@@ src/bfa_table_mem.sv @@
// Block table storage: one write port, one read port, registered read data.
// Depends on bfa_pkg for the entry type.
module bfa_table_mem import bfa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS = MAX_BLOCKS_DEF,
  localparam int unsigned IDX_W     = $clog2(MAX_BLOCKS)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [IDX_W-1:0] waddr_i,
  input  entry_t           wdata_i,
  input  logic             re_i,
  input  logic [IDX_W-1:0] raddr_i,
  output entry_t           rdata_o
);

  entry_t mem_q [MAX_BLOCKS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/bfa_cfg_regs.sv @@
// APB-style configuration registers: heap base and heap limit.
// Depends on bfa_pkg for register indexes and the config struct.
module bfa_cfg_regs import bfa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  logic [31:0] base_q;
  logic [31:0] limit_q;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= HEAP_BASE_RST;
      limit_q <= HEAP_LIMIT_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_HEAP_BASE) begin
        base_q <= pwdata;
      end else begin
        limit_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEAP_BASE) ? base_q : limit_q;

  // The heap top reloads at the same edge that writes the base.
  assign cfg_o.limit        = limit_q;
  assign cfg_o.reload       = wr_en && (paddr[2] == REG_HEAP_BASE);
  assign cfg_o.reload_value = pwdata;

endmodule

@@ src/bfa_ctrl.sv @@
// Allocator controller: scans the block table, picks the best fit or a match (or appends
// a new entry), writes back the entry and holds the response register.
// Depends on bfa_pkg; drives bfa_table_mem.
module bfa_ctrl import bfa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF,
  localparam int unsigned IDX_W       = $clog2(MAX_BLOCKS),
  localparam int unsigned CNT_W       = $clog2(MAX_BLOCKS + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cfg_t             cfg_i,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  logic             req_cmd_i,
  input  logic [31:0]      req_size_i,
  input  logic [31:0]      req_addr_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output logic [31:0]      rsp_addr_o,
  output status_e          rsp_status_o,
  output logic             mem_we_o,
  output logic [IDX_W-1:0] mem_waddr_o,
  output entry_t           mem_wdata_o,
  output logic             mem_re_o,
  output logic [IDX_W-1:0] mem_raddr_o,
  input  entry_t           mem_rdata_i
);

  state_e           state_q, state_d;
  logic             cmd_q;
  logic [32:0]      rsize_q;
  logic [31:0]      addr_q;
  logic [CNT_W-1:0] issue_q;
  logic             cmp_valid_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  entry_t           best_q;
  logic [CNT_W-1:0] count_q;
  logic [31:0]      heap_top_q;
  logic             rsp_valid_q;
  logic [31:0]      rsp_addr_q;
  status_e          rsp_status_q;

  logic        accept;
  logic        slot_free;
  logic        done;
  logic        fits, better, match, take;
  logic [33:0] new_top;
  logic        table_full, over_limit;
  logic        append;
  logic [31:0] res_addr;
  status_e     res_status;
  logic [32:0] rsize_in;

  assign rsize_in  = ({1'b0, req_size_i} + 33'd3) & ~33'd3;
  assign slot_free = !rsp_valid_q || rsp_ready_i;

  // Per-entry compare on the registered read data.
  assign fits   = mem_rdata_i.free && ({1'b0, mem_rdata_i.size} >= rsize_q);
  assign better = !found_q || (mem_rdata_i.size < best_q.size);
  assign match  = (({1'b0, mem_rdata_i.start} + 33'(HEADER_BYTES)) == {1'b0, addr_q});
  assign take   = cmp_valid_q &&
                  ((cmd_q == CMD_ALLOC) ? (fits && better) : (match && !found_q));

  assign new_top    = {2'b00, heap_top_q} + {1'b0, rsize_q} + 34'(HEADER_BYTES);
  assign table_full = (count_q == CNT_W'(MAX_BLOCKS));
  assign over_limit = new_top > {2'b00, cfg_i.limit};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if ((issue_q == count_q) && !cmp_valid_q) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (slot_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs and write-back decision.
  always_comb begin
    req_ready_o = (state_q == S_IDLE);
    accept      = req_ready_o && req_valid_i;
    mem_re_o    = (state_q == S_SCAN) && (issue_q != count_q);
    mem_raddr_o = issue_q[IDX_W-1:0];
    done        = (state_q == S_DECIDE) && slot_free;

    mem_we_o    = 1'b0;
    mem_waddr_o = best_idx_q;
    mem_wdata_o = best_q;
    append      = 1'b0;
    res_addr    = 32'd0;
    res_status  = ST_OK;

    if (cmd_q == CMD_ALLOC) begin
      if (found_q) begin
        mem_we_o         = done;
        mem_wdata_o.free = 1'b0;
        res_addr         = best_q.start + 32'(HEADER_BYTES);
      end else if (table_full || over_limit) begin
        res_status = ST_NO_ROOM;
      end else begin
        append            = done;
        mem_we_o          = done;
        mem_waddr_o       = count_q[IDX_W-1:0];
        mem_wdata_o.free  = 1'b0;
        mem_wdata_o.size  = rsize_q[31:0];
        mem_wdata_o.start = heap_top_q;
        res_addr          = heap_top_q + 32'(HEADER_BYTES);
      end
    end else begin
      // A free of address zero is ignored and reports success.
      if (addr_q != 32'd0) begin
        if (found_q) begin
          mem_we_o         = done;
          mem_wdata_o.free = 1'b1;
        end else begin
          res_status = ST_UNKNOWN;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issue_q     <= '0;
      cmp_valid_q <= 1'b0;
      found_q     <= 1'b0;
      count_q     <= '0;
      heap_top_q  <= HEAP_BASE_RST;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmp_valid_q <= mem_re_o;
      if (accept) begin
        issue_q <= '0;
        found_q <= 1'b0;
      end else begin
        if (mem_re_o) issue_q <= issue_q + CNT_W'(1);
        if (take) found_q <= 1'b1;
      end
      if (done) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      if (append) begin
        count_q    <= count_q + CNT_W'(1);
        heap_top_q <= new_top[31:0];
      end
      if (cfg_i.reload) begin
        heap_top_q <= cfg_i.reload_value;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= req_cmd_i;
      rsize_q <= rsize_in;
      addr_q  <= req_addr_i;
    end
    cmp_idx_q <= issue_q[IDX_W-1:0];
    if (take) begin
      best_idx_q <= cmp_idx_q;
      best_q     <= mem_rdata_i;
    end
    if (done) begin
      rsp_addr_q   <= res_addr;
      rsp_status_q <= res_status;
    end
  end

  assign rsp_valid_o  = rsp_valid_q;
  assign rsp_addr_o   = rsp_addr_q;
  assign rsp_status_o = rsp_status_q;

endmodule

@@ src/best_fit_block_allocator_core.sv @@
// Top level of the best-fit block allocator with bump fallback.
// Depends on bfa_pkg, bfa_req_if, bfa_rsp_if, bfa_cfg_regs, bfa_table_mem, bfa_ctrl.
//
//   Channel   Direction  Handshake              Payload
//   req_i     in         req_i.valid/ready      cmd, req_size, release_address
//   rsp_o     out        rsp_o.valid/ready      data_address, status
//   APB       in         psel,penable,pwrite    paddr, pwdata, prdata (pready tied high)
//
// One request is handled at a time. After the accepting edge the controller
// reads the block table one entry per cycle through the single read port of the
// table memory, up to the entry count. The decision cycle waits while an earlier
// result is still held in the output register. Reset clears the entry count,
// the heap top, the configuration registers and all handshake state; the table
// contents stay undefined and are never read beyond the entry count, so no
// clearing pass runs.
module best_fit_block_allocator_core import bfa_pkg::*; #(
  parameter int unsigned MAX_BLOCKS   = MAX_BLOCKS_DEF,
  parameter int unsigned HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bfa_req_if.sink               req_i,
  bfa_rsp_if.source             rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);

  cfg_t             cfg;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  entry_t           mem_rdata;
  status_e          rsp_status;

  // Configuration registers; a write to the heap base also reloads the heap top.
  bfa_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Block table: start, size and free flag of each entry in one memory word.
  bfa_table_mem #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // The controller scans, decides and writes back at most one entry per request.
  // Table writes only happen in the decision cycle, after the scan is over, so a
  // read never overlaps a write to the same entry.
  bfa_ctrl #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .req_valid_i  (req_i.valid),
    .req_ready_o  (req_i.ready),
    .req_cmd_i    (req_i.cmd),
    .req_size_i   (req_i.req_size),
    .req_addr_i   (req_i.release_address),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .rsp_addr_o   (rsp_o.data_address),
    .rsp_status_o (rsp_status),
    .mem_we_o     (mem_we),
    .mem_waddr_o  (mem_waddr),
    .mem_wdata_o  (mem_wdata),
    .mem_re_o     (mem_re),
    .mem_raddr_o  (mem_raddr),
    .mem_rdata_i  (mem_rdata)
  );

  assign rsp_o.status = rsp_status;

endmodule
